// File: src/nnps_pkg.sv
package nnps_pkg;

    localparam int WINDOW_COLS_DEF = 12;
    localparam int COEF_DEPTH_DEF  = 256;
    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 18;
    localparam int ACC_W           = 40;
    localparam int ACT_W           = 22;
    localparam int QUO_W           = 17;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    localparam logic [7:0] PRESCREEN_PASS = 8'd255;
    localparam logic [7:0] PRESCREEN_FAIL = 8'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MAC,
        ST_BIAS,
        ST_ACT,
        ST_DIV,
        ST_DIVEND,
        ST_NEXT,
        ST_OUT
    } nnps_state_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
            begin
                return s[ACC_W] ? ACC_MIN : ACC_MAX;
            end
            return s[ACC_W-1:0];
        end
    endfunction

endpackage

// File: src/nn_prescreen_4x12_window_core.sv
// Prescreen core: 4-row sliding window feeding a small three-layer network.
//
// Input channel s_axis: one item is either a coefficient load (opcode 0,
// writes one word of the coefficient RAM) or a pixel column push (opcode 1).
// A push shifts four new samples into the right end of the window; row_start
// restarts the fill count. Once WINDOW_COLS columns have arrived since the
// last row start, every push yields one prescreen byte on m_axis.
//
// Load and push: a load writes the RAM and gives no item. A push that completes
// the window runs the shared MAC and the shared divider under one sequencer:
// per layer-0 neuron 4*WINDOW_COLS taps plus bias, per layer-1 neuron 4
// products, per layer-2 neuron 8 products, each product needing a RAM read
// and then a MAC step, plus 7 Elliott divisions. From a push that completes
// the window, s_axis_tready stays low until the result is taken and returns
// the cycle after it is taken, so the core takes no new item before it is
// through with the last. The shared multiplier and serial divider set this.
//
// Reset clears the window, the fill count and the sequencer. The coefficient
// RAM is not cleared; every used word must be loaded before the first push.
// When m_axis stalls the result is held in the output register and the core
// waits in its output state, input not ready, until the item is taken.
module nn_prescreen_4x12_window_core
    #(
    parameter int WINDOW_COLS = nnps_pkg::WINDOW_COLS_DEF,
    parameter int COEF_DEPTH  = nnps_pkg::COEF_DEPTH_DEF
    )
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[0], coef_index[8:1], coef_value[26:9], row_start[27],
    // sample_top[43:28], sample_second[59:44], sample_third[75:60],
    // sample_bottom[91:76], zero pad[95:92]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // prescreen_value[7:0]
    output logic [7:0]  m_axis_tdata
    );
    import nnps_pkg::*;

    localparam int NTAPS = 4 * WINDOW_COLS;
    localparam int AW    = $clog2(COEF_DEPTH);
    localparam int MW    = $clog2(NTAPS + 1);
    localparam int FW    = $clog2(WINDOW_COLS + 1);
    localparam int B0    = NTAPS * 4;
    localparam int K1    = B0 + 4;
    localparam int B1    = K1 + 16;
    localparam int K2    = B1 + 4;
    localparam int B2    = K2 + 32;
    localparam int CAW   = $clog2(B2 + 4 + 1);

    // unpack the input item
    logic              in_op;
    logic [7:0]        in_idx;
    logic [COEF_W-1:0] in_coef;
    logic              in_rs;
    logic [SAMPLE_W-1:0] in_s [4];
    assign in_op   = s_axis_tdata[0];
    assign in_idx  = s_axis_tdata[8:1];
    assign in_coef = s_axis_tdata[26:9];
    assign in_rs   = s_axis_tdata[27];
    assign in_s[0] = s_axis_tdata[43:28];
    assign in_s[1] = s_axis_tdata[59:44];
    assign in_s[2] = s_axis_tdata[75:60];
    assign in_s[3] = s_axis_tdata[91:76];

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // window and fill count
    logic [SAMPLE_W-1:0] win_reg [NTAPS];
    logic [FW-1:0]       fill_reg;
    logic [FW-1:0]       fill_next;

    always_comb
    begin
        fill_next = in_rs ? '0 : fill_reg;
        if (fill_next < FW'(WINDOW_COLS))
        begin
            fill_next = fill_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < NTAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (in_acc && in_op == OP_PUSH)
        begin
            fill_reg <= fill_next;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < WINDOW_COLS - 1; c++)
                begin
                    win_reg[r*WINDOW_COLS+c] <= win_reg[r*WINDOW_COLS+c+1];
                end
                win_reg[r*WINDOW_COLS+WINDOW_COLS-1] <= in_s[r];
            end
        end
    end

    // coefficient RAM
    logic [AW-1:0]     ram_raddr;
    logic [COEF_W-1:0] ram_rdata;
    logic              ram_we;
    assign ram_we = in_acc && in_op == OP_LOAD && 32'(in_idx) < COEF_DEPTH;

    nnps_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(in_idx)),
        .wdata(in_coef),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // sequencer state
    nnps_state_t state_reg, state_next;
    logic [1:0]     layer_reg, layer_next;
    logic [1:0]     neu_reg, neu_next;
    logic [MW-1:0]  k_reg, k_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACT_W-1:0] act_reg [8];
    logic [ACT_W-1:0] act_next_val;
    logic             act_we;
    logic [2:0]       act_wsel;
    logic [ACC_W-1:0] l2_reg [4];
    logic             l2_we;
    // divider
    logic [ACC_W+16:0] rem_reg, rem_next;
    logic [ACC_W:0]    den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [4:0]        dcnt_reg, dcnt_next;
    logic              neg_reg, neg_next;
    logic [7:0]        out_reg, out_next;
    logic              outv_reg, outv_next;

    logic [MW-1:0] kmax;
    logic [CAW-1:0] caddr;
    logic              coef_oob_reg;
    logic [COEF_W-1:0] coef_q;
    logic [SAMPLE_W+COEF_W-1:0] prod0;
    logic [ACT_W+COEF_W-1:0]    prod1;
    logic [ACC_W-1:0] term, bias_term, mag;
    logic [ACC_W-1:0] lin_y;
    logic [ACC_W-1:0] lo_max, hi_max;

    // words past the end of the RAM read as zero
    assign coef_q = coef_oob_reg ? '0 : ram_rdata;

    always_comb
    begin
        case (layer_reg)
            2'd0:    kmax = MW'(NTAPS);
            2'd1:    kmax = MW'(4);
            default: kmax = MW'(8);
        endcase
    end

    always_comb
    begin
        case (layer_reg)
            2'd0:    caddr = CAW'(k_reg) * CAW'(4) + CAW'(neu_reg);
            2'd1:    caddr = CAW'(K1) + CAW'(k_reg[2:0]) * CAW'(4) + CAW'(neu_reg);
            default: caddr = CAW'(K2) + CAW'(k_reg[2:0]) * CAW'(4) + CAW'(neu_reg);
        endcase
        if (state_reg == ST_BIAS || k_reg == kmax)
        begin
            case (layer_reg)
                2'd0:    caddr = CAW'(B0) + CAW'(neu_reg);
                2'd1:    caddr = CAW'(B1) + CAW'(neu_reg);
                default: caddr = CAW'(B2) + CAW'(neu_reg);
            endcase
        end
        ram_raddr = AW'(caddr);
    end

    // shared multiply
    always_comb
    begin
        prod0 = $signed(win_reg[k_reg[MW-1:0] < MW'(NTAPS) ? k_reg : '0])
                * $signed(coef_q);
        prod1 = $signed(act_reg[k_reg[2:0]]) * $signed(coef_q);
        if (layer_reg == 2'd0)
        begin
            term = ACC_W'($signed(prod0));
            bias_term = ACC_W'($signed({coef_q, 12'b0}));
        end
        else
        begin
            term = ACC_W'($signed(prod1));
            bias_term = ACC_W'($signed({coef_q, 16'b0}));
        end
        mag = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        lin_y = ACC_W'($signed(acc_reg) >>> 10);
        lo_max = ($signed(l2_reg[0]) > $signed(l2_reg[1])) ? l2_reg[0] : l2_reg[1];
        hi_max = ($signed(l2_reg[2]) > $signed(l2_reg[3])) ? l2_reg[2] : l2_reg[3];
    end

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        neu_next   = neu_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        out_next   = out_reg;
        outv_next  = outv_reg;
        act_we     = 1'b0;
        act_wsel   = 3'(layer_reg == 2'd1) * 3'd4 + 3'(neu_reg);
        act_next_val = '0;
        l2_we      = 1'b0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_acc && in_op == OP_PUSH && fill_next == FW'(WINDOW_COLS))
                begin
                    state_next = ST_ADDR;
                    layer_next = 2'd0;
                    neu_next   = 2'd0;
                    k_next     = '0;
                    acc_next   = '0;
                end
            end
            ST_ADDR:
            begin
                // RAM read of current address is under way
                state_next = (k_reg == kmax) ? ST_BIAS : ST_MAC;
            end
            ST_MAC:
            begin
                acc_next   = sat_add(acc_reg, term);
                k_next     = k_reg + 1'b1;
                state_next = ST_ADDR;
            end
            ST_BIAS:
            begin
                acc_next   = sat_add(acc_reg, bias_term);
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (layer_reg == 2'd2)
                begin
                    l2_we = 1'b1;
                    state_next = ST_NEXT;
                end
                else if (layer_reg == 2'd0 && neu_reg == 2'd0)
                begin
                    act_we = 1'b1;
                    if ($signed(lin_y) > $signed(ACC_W'(2097151)))
                        act_next_val = 22'h1FFFFF;
                    else if ($signed(lin_y) < $signed(-ACC_W'(2097152)))
                        act_next_val = 22'h200000;
                    else
                        act_next_val = lin_y[ACT_W-1:0];
                    state_next = ST_NEXT;
                end
                else
                begin
                    neg_next  = acc_reg[ACC_W-1];
                    rem_next  = {1'b0, mag, 16'b0};
                    den_next  = (layer_reg == 2'd0)
                                ? ({1'b0, mag} + (ACC_W+1)'(64'd1 << 26))
                                : ({1'b0, mag} + (ACC_W+1)'(64'd1 << 30));
                    quo_next  = '0;
                    dcnt_next = 5'(QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle, msb first
                if (({den_reg, 16'b0} >> (16 - dcnt_reg)) <= (ACC_W+17)'(rem_reg)
                    && (({den_reg, 16'b0} >> (16 - dcnt_reg)) >> dcnt_reg)
                       == (ACC_W+17)'(den_reg))
                begin
                    rem_next = rem_reg - (({den_reg, 16'b0} >> (16 - dcnt_reg)));
                    quo_next = quo_reg | (QUO_W'(1) << dcnt_reg);
                end
                if (dcnt_reg == '0)
                    state_next = ST_DIVEND;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            ST_DIVEND:
            begin
                act_we = 1'b1;
                act_next_val = neg_reg ? -ACT_W'(quo_reg) : ACT_W'(quo_reg);
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                k_next   = '0;
                acc_next = '0;
                state_next = ST_ADDR;
                neu_next = neu_reg + 1'b1;
                if (neu_reg == 2'd3)
                begin
                    if (layer_reg == 2'd2)
                    begin
                        out_next  = ($signed(hi_max) <= $signed(lo_max))
                                    ? PRESCREEN_PASS : PRESCREEN_FAIL;
                        outv_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        layer_next = layer_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    outv_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
            layer_reg <= '0;
            neu_reg   <= '0;
            k_reg     <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            outv_reg  <= outv_next;
            layer_reg <= layer_next;
            neu_reg   <= neu_next;
            k_reg     <= k_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
        coef_oob_reg <= (32'(caddr) >= COEF_DEPTH);
        if (act_we)
        begin
            act_reg[act_wsel] <= act_next_val;
        end
        if (l2_we)
        begin
            l2_reg[neu_reg] <= acc_reg;
        end
    end

    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// File: src/nnps_ram.sv
module nnps_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/nnps_checker.sv
module nnps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import nnps_pkg::*;

    a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata == PRESCREEN_PASS || m_axis_tdata == PRESCREEN_FAIL))
        else $error("bad prescreen code");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind nn_prescreen_4x12_window_core nnps_checker u_nnps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
